[rtl/sepp_pkg.sv]
// Shared constants and types for the sensor ensemble packet parser.
// No dependencies.
`default_nettype none
package sepp_pkg;

   localparam int HDR_BYTES      = 6;
   localparam int BUF_DEPTH      = 36;
   localparam int MAX_TEXT_CHARS = 32;
   localparam int ADDR_W         = 6;

   localparam logic [16:0] POS_MAX       = 17'h1FFFF;
   localparam logic [63:0] Q_ONE         = 64'h1000_0000_0000_0000;
   localparam logic [63:0] SQRT_TOP_BIT  = 64'h4000_0000_0000_0000;
   localparam logic [15:0] HEADING_LIMIT = 16'd714;

   // result kinds
   localparam logic [2:0] KIND_TEMP   = 3'd0;
   localparam logic [2:0] KIND_RAW    = 3'd1;
   localparam logic [2:0] KIND_QUAT   = 3'd2;
   localparam logic [2:0] KIND_TEXT   = 3'd3;
   localparam logic [2:0] KIND_STATUS = 3'd4;

   // register indexes
   localparam logic [1:0] REG_TEMP_CODE = 2'd0;
   localparam logic [1:0] REG_RAW_CODE  = 2'd1;
   localparam logic [1:0] REG_QUAT_CODE = 2'd2;
   localparam logic [1:0] REG_TEXT_CODE = 2'd3;

   // register defaults
   localparam logic [3:0] TEMP_CODE_RST = 4'd1;
   localparam logic [3:0] RAW_CODE_RST  = 4'd12;
   localparam logic [3:0] QUAT_CODE_RST = 4'd13;
   localparam logic [3:0] TEXT_CODE_RST = 4'd15;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_QRD  = 9'b000000010,
      ST_QCAP = 9'b000000100,
      ST_QMUL = 9'b000001000,
      ST_QADD = 9'b000010000,
      ST_SQRT = 9'b000100000,
      ST_RD   = 9'b001000000,
      ST_EMIT = 9'b010000000,
      ST_STAT = 9'b100000000
   } sepp_state_type;

endpackage
`default_nettype wire

[rtl/sensor_ensemble_packet_parser_unit.sv]
// Sensor ensemble packet parser, top level.
// Depends on sepp_pkg.
`default_nettype none
// Usage:
//   req_* : one packet byte per beat, tlast on the final byte of a packet.
//   rsp_* : one parsed value per beat, tlast on the final value a byte causes.
//   csr_* : writes record type codes (0 temp, 1 raw imu, 2 quat imu, 3 text);
//           always ready; the user must write only while the parser is idle (unenforced).
// Intake: a byte that does not finish a record or packet leaves the parser idle,
//   so req_tready stays high for the next byte. A finished record is read back
//   from the 36-byte record memory one value at a time (read state, then load
//   of the output register, which waits for a free output). Quaternion records
//   first spend 6 read/capture pairs, 3 multiply/add pairs and 32 square root
//   steps before value 0. A packet status beat is loaded in the status state
//   after the record values (or after the closing byte).
// Stall: the output register holds while rsp_tready is low; the sequencer
//   waits and req_tready stays low until the byte's values are all loaded.
// Reset: synchronous, active high; type codes return to 1/12/13/15 and packet
//   position, length and record fill are cleared; the record memory is not.
module sensor_ensemble_packet_parser_unit
   import sepp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire         req_tlast,   // packet_end
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [27:0] timestamp, [33:28] item_index, [65:34] item_value,
   // [66] packet_ok, [71:67] zero
   output logic [71:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] record_kind
   output logic        rsp_tlast,   // last_result
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [3:0]  csr_data
);

   sepp_state_type st_ff, st_in;

   logic [3:0]  treg_ff [4];
   logic [16:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [5:0]  fill_ff, fill_in;
   logic        stop_ff, stop_in;
   logic [31:0] hdr_ff, hdr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  cur_ff, cur_in;
   logic        lastp_ff, lastp_in;
   logic        ok_ff, ok_in;
   logic [5:0]  idx_ff, idx_in;
   logic [2:0]  qsel_ff, qsel_in;
   logic [1:0]  k_ff, k_in;
   logic [31:0] qw_ff [3];
   logic [31:0] qw_in [3];
   logic [63:0] sq_ff, sq_in;
   logic [63:0] sum_ff, sum_in;
   logic [63:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [31:0] q0_ff, q0_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_user_ff, rsp_user_in;
   logic        rsp_last_ff, rsp_last_in;

   // record memory
   logic [7:0]  mem [BUF_DEPTH];
   logic [7:0]  rd0_ff, rd1_ff;
   logic        selcur_ff;
   logic        wr_en, rd_en;
   logic [ADDR_W-1:0] ra0, ra0c, ra1c;

   logic        acc;
   logic        take;
   logic [5:0]  fill_inc;
   logic [3:0]  tcode;
   logic        known;
   logic [2:0]  mkind;
   logic [5:0]  bclamp, tcnt;
   logic [5:0]  need;
   logic        done;
   logic [16:0] pos_next;
   logic        out_free, load;
   logic [31:0] s16, val;
   logic [5:0]  last_idx;
   logic [31:0] mag;
   logic [63:0] sq_sum, trial;

   assign acc        = req_tvalid && req_tready;
   assign req_tready = (st_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load       = out_free && ((st_ff == ST_EMIT) || (st_ff == ST_STAT));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // byte intake: header, length and record bookkeeping
   always_comb begin
      fill_inc = fill_ff + 6'd1;
      pos_next = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 17'd1;
      take     = (pos_ff >= 17'(HDR_BYTES)) &&
                 (pos_ff < ({1'b0, len_ff} + 17'(HDR_BYTES))) && !stop_ff;
      tcode    = (fill_ff == 6'd0) ? req_tdata[3:0] : hdr_ff[3:0];
      known    = 1'b1;
      if (treg_ff[REG_TEMP_CODE] == tcode)      mkind = KIND_TEMP;
      else if (treg_ff[REG_RAW_CODE] == tcode)  mkind = KIND_RAW;
      else if (treg_ff[REG_QUAT_CODE] == tcode) mkind = KIND_QUAT;
      else if (treg_ff[REG_TEXT_CODE] == tcode) mkind = KIND_TEXT;
      else begin
         mkind = KIND_TEMP;
         known = 1'b0;
      end
      bclamp = (req_tdata > 8'(MAX_TEXT_CHARS)) ? 6'(MAX_TEXT_CHARS) : req_tdata[5:0];
      tcnt   = (fill_ff == 6'd4) ? bclamp : cnt_ff;
      case (mkind)
         KIND_TEMP: need = 6'd7;
         KIND_RAW:  need = 6'd22;
         KIND_QUAT: need = 6'd36;
         default:   need = (fill_inc < 6'd5) ? 6'd5 : 6'd5 + tcnt;
      endcase
      done  = take && (fill_inc >= 6'd4) && known && (fill_inc >= need);
      wr_en = acc && take && (fill_ff < 6'(BUF_DEPTH));
   end

   // output value of the current item
   always_comb begin
      s16 = {{16{rd1_ff[7]}}, rd1_ff, rd0_ff};
      case (kind_ff)
         KIND_TEMP: val = (idx_ff == 6'd0) ? s16 : {31'd0, rd0_ff != 8'd0};
         KIND_RAW:  val = s16;
         KIND_QUAT: begin
            case (idx_ff)
               6'd9:    val = q0_ff;
               6'd10:   val = qw_ff[0];
               6'd11:   val = qw_ff[1];
               6'd12:   val = qw_ff[2];
               6'd14:   val = {31'd0, rd1_ff[7] || ({rd1_ff, rd0_ff} <= HEADING_LIMIT)};
               default: val = s16;
            endcase
         end
         default: val = (idx_ff == 6'd0) ? {26'd0, cnt_ff} :
                        {24'd0, selcur_ff ? cur_ff : rd0_ff};
      endcase
      case (kind_ff)
         KIND_TEMP: last_idx = 6'd1;
         KIND_RAW:  last_idx = 6'd8;
         KIND_QUAT: last_idx = 6'd14;
         default:   last_idx = cnt_ff;
      endcase
   end

   // read address
   always_comb begin
      if (st_ff == ST_QRD) ra0 = 6'd22 + {2'b0, qsel_ff, 1'b0};
      else if (kind_ff == KIND_TEXT) ra0 = 6'd4 + idx_ff;
      else if (idx_ff < 6'd9) ra0 = 6'd4 + {idx_ff[4:0], 1'b0};
      else ra0 = 6'd34;
      ra0c  = (ra0 < 6'(BUF_DEPTH)) ? ra0 : '0;
      ra1c  = (ra0 + 6'd1 < 6'(BUF_DEPTH)) ? ra0 + 6'd1 : ra0c;
      rd_en = (st_ff == ST_QRD) || (st_ff == ST_RD);
   end

   // quaternion magnitude square and square root step
   always_comb begin
      mag    = qw_ff[k_ff][31] ? (~qw_ff[k_ff] + 32'd1) : qw_ff[k_ff];
      sq_sum = sum_ff + sq_ff;
      trial  = r_ff + bit_ff;
   end

   // sequencer
   always_comb begin
      st_in    = st_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      fill_in  = fill_ff;
      stop_in  = stop_ff;
      hdr_in   = hdr_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      cur_in   = cur_ff;
      lastp_in = lastp_ff;
      ok_in    = ok_ff;
      idx_in   = idx_ff;
      qsel_in  = qsel_ff;
      k_in     = k_ff;
      qw_in    = qw_ff;
      sq_in    = sq_ff;
      sum_in   = sum_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      q0_in    = q0_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
      case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               cur_in   = req_tdata;
               lastp_in = req_tlast;
               pos_in   = pos_next;
               ok_in    = pos_next >= 17'(HDR_BYTES);
               if (pos_ff == 17'd4) begin
                  len_in = {8'd0, req_tdata};
               end else if (pos_ff == 17'd5) begin
                  len_in = {req_tdata, len_ff[7:0]};
               end else if (take) begin
                  fill_in = fill_inc;
                  if (fill_ff < 6'd4) hdr_in[fill_ff[1:0]*8 +: 8] = req_tdata;
                  if (fill_ff == 6'd4) cnt_in = bclamp;
                  if (fill_inc >= 6'd4) begin
                     if (!known) begin
                        stop_in = 1'b1;
                        fill_in = '0;
                     end else if (done) begin
                        fill_in = '0;
                        kind_in = mkind;
                     end
                  end
               end
               if (done) begin
                  idx_in = '0;
                  if (mkind == KIND_QUAT) begin
                     st_in   = ST_QRD;
                     qsel_in = '0;
                     sum_in  = '0;
                  end else begin
                     st_in = ST_RD;
                  end
               end else if (req_tlast) begin
                  st_in = ST_STAT;
               end
               if (req_tlast) begin
                  pos_in  = '0;
                  len_in  = '0;
                  fill_in = '0;
                  stop_in = 1'b0;
               end
            end
         end
         ST_QRD:  st_in = ST_QCAP;
         ST_QCAP: begin
            qw_in[qsel_ff[2:1]][qsel_ff[0]*16 +: 16] = {rd1_ff, rd0_ff};
            if (qsel_ff == 3'd5) begin
               st_in = ST_QMUL;
               k_in  = '0;
            end else begin
               qsel_in = qsel_ff + 3'd1;
               st_in   = ST_QRD;
            end
         end
         ST_QMUL: begin
            sq_in = mag * mag;
            st_in = ST_QADD;
         end
         ST_QADD: begin
            sum_in = sq_sum;
            if (k_ff == 2'd2) begin
               v_in   = (sq_sum >= Q_ONE) ? 64'd0 : Q_ONE - sq_sum;
               r_in   = '0;
               bit_in = SQRT_TOP_BIT;
               st_in  = ST_SQRT;
            end else begin
               k_in  = k_ff + 2'd1;
               st_in = ST_QMUL;
            end
         end
         ST_SQRT: begin
            if (v_ff >= trial) begin
               v_in = v_ff - trial;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) begin
               q0_in = r_in[31:0];
               st_in = ST_RD;
            end
         end
         ST_RD:   st_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               rsp_data_in = {5'd0, 1'b0, val, idx_ff, hdr_ff[31:4]};
               rsp_user_in = kind_ff;
               rsp_last_in = (idx_ff == last_idx) && !lastp_ff;
               if (idx_ff == last_idx) begin
                  st_in = lastp_ff ? ST_STAT : ST_IDLE;
               end else begin
                  idx_in = idx_ff + 6'd1;
                  st_in  = ST_RD;
               end
            end
         end
         ST_STAT: begin
            if (out_free) begin
               rsp_data_in = {5'd0, ok_ff, 32'd0, 6'd0, 28'd0};
               rsp_user_in = KIND_STATUS;
               rsp_last_in = 1'b1;
               st_in       = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[fill_ff] <= req_tdata;
      if (rd_en) begin
         rd0_ff    <= mem[ra0c];
         rd1_ff    <= mem[ra1c];
         selcur_ff <= (ra0 == 6'(BUF_DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff                  <= ST_IDLE;
         treg_ff[REG_TEMP_CODE] <= TEMP_CODE_RST;
         treg_ff[REG_RAW_CODE]  <= RAW_CODE_RST;
         treg_ff[REG_QUAT_CODE] <= QUAT_CODE_RST;
         treg_ff[REG_TEXT_CODE] <= TEXT_CODE_RST;
         pos_ff       <= '0;
         len_ff       <= '0;
         fill_ff      <= '0;
         stop_ff      <= 1'b0;
         lastp_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         if (csr_valid) treg_ff[csr_index] <= csr_data;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         stop_ff      <= stop_in;
         lastp_ff     <= lastp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff      <= hdr_in;
      cnt_ff      <= cnt_in;
      kind_ff     <= kind_in;
      cur_ff      <= cur_in;
      ok_ff       <= ok_in;
      idx_ff      <= idx_in;
      qsel_ff     <= qsel_in;
      k_ff        <= k_in;
      qw_ff       <= qw_in;
      sq_ff       <= sq_in;
      sum_ff      <= sum_in;
      v_ff        <= v_in;
      r_ff        <= r_in;
      bit_ff      <= bit_in;
      q0_ff       <= q0_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 6'd37)
      else $error("record fill out of range");
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (pos_ff == 17'd0 && fill_ff == 6'd0))
      else $error("packet state not cleared after final byte");
   a_q0_bound: assert property (@(posedge clock) disable iff (reset)
      ($past(st_ff) == ST_SQRT && st_ff == ST_RD) |-> (q0_ff <= 32'h4000_0000))
      else $error("q0 above one");
`endif

endmodule
`default_nettype wire

[tb/sensor_ensemble_packet_parser_unit_tb.sv]
// Testbench for the sensor ensemble packet parser: byte stream in, parsed values out.
// Holds its own packet parser model and checks every value beat against it.
// Depends on sepp_pkg and sensor_ensemble_packet_parser_unit.
`timescale 1ns / 1ps
module sensor_ensemble_packet_parser_unit_tb
   import sepp_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic [2:0]  kind;
      logic [27:0] ms;
      logic [5:0]  idx;
      logic [31:0] val;
      logic        ok;
      logic        last;
   } value_beat_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } pkt_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [3:0]  csr_data = '0;

   sensor_ensemble_packet_parser_unit u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // pending bytes and values still owed by the parser
   pkt_byte_type   byte_q[$];
   value_beat_type value_q[$];
   logic [7:0]     body[$];

   int  errors = 0;
   int  cycles = 0;
   int  n_bytes = 0;
   int  n_values = 0;
   int  n_packets = 0;
   bit  no_idle = 1'b0;
   bit  hold_toggle = 1'b0;

   // model state
   logic [3:0]  type_code[4];
   logic [16:0] byte_pos;
   logic [15:0] pay_len;
   logic [7:0]  rec_mem[36];
   logic [5:0]  rec_fill;
   bit          stopped;

   function automatic logic [31:0] root64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r[31:0];
   endfunction

   function automatic logic [63:0] mag_sq(logic [31:0] w);
      logic [63:0] m;
      m = w[31] ? {32'h0, (~w) + 32'h1} : {32'h0, w};
      if (w == 32'h8000_0000) m = 64'h8000_0000;
      return m * m;
   endfunction

   function automatic logic [7:0] rec_at(int i, logic [7:0] cur);
      return (i < BUF_DEPTH) ? rec_mem[i] : cur;
   endfunction

   function automatic logic [31:0] rec_s16(int i, logic [7:0] cur);
      logic [15:0] h;
      h = {rec_at(i + 1, cur), rec_at(i, cur)};
      return {{16{h[15]}}, h};
   endfunction

   function automatic logic [31:0] rec_u32(int i, logic [7:0] cur);
      return {rec_at(i + 3, cur), rec_at(i + 2, cur), rec_at(i + 1, cur), rec_at(i, cur)};
   endfunction

   task automatic push_value(logic [2:0] k, logic [27:0] ms, int idx, logic [31:0] v,
                             logic ok);
      value_beat_type e;
      e.kind = k; e.ms = ms; e.idx = idx[5:0]; e.val = v; e.ok = ok; e.last = 1'b0;
      value_q = {value_q, e};
   endtask

   task automatic emit_record(int k, logic [7:0] cur);
      logic [27:0] ms;
      logic [31:0] q1, q2, q3, acc, c;
      logic [63:0] s;
      logic [2:0]  kc;
      ms = 28'(rec_u32(0, cur) >> 4);
      case (k)
         KIND_TEMP: begin
            push_value(KIND_TEMP, ms, 0, rec_s16(4, cur), 1'b0);
            push_value(KIND_TEMP, ms, 1, (rec_at(6, cur) != 0) ? 32'd1 : 32'd0, 1'b0);
         end
         KIND_RAW, KIND_QUAT: begin
            kc = (k == KIND_RAW) ? KIND_RAW : KIND_QUAT;
            for (int i = 0; i < 9; i++)
               push_value(kc, ms, i, rec_s16(4 + 2 * i, cur), 1'b0);
            if (k == KIND_QUAT) begin
               q1 = rec_u32(22, cur);
               q2 = rec_u32(26, cur);
               q3 = rec_u32(30, cur);
               s = mag_sq(q1) + mag_sq(q2) + mag_sq(q3);
               acc = rec_s16(34, cur);
               push_value(KIND_QUAT, ms, 9, (s >= Q_ONE) ? 32'd0 : root64(Q_ONE - s), 1'b0);
               push_value(KIND_QUAT, ms, 10, q1, 1'b0);
               push_value(KIND_QUAT, ms, 11, q2, 1'b0);
               push_value(KIND_QUAT, ms, 12, q3, 1'b0);
               push_value(KIND_QUAT, ms, 13, acc, 1'b0);
               push_value(KIND_QUAT, ms, 14, (acc[31] || acc <= 714) ? 32'd1 : 32'd0, 1'b0);
            end
         end
         default: begin
            c = {24'h0, rec_at(4, cur)};
            if (c > MAX_TEXT_CHARS) c = MAX_TEXT_CHARS;
            push_value(KIND_TEXT, ms, 0, c, 1'b0);
            for (int i = 0; i < c; i++)
               push_value(KIND_TEXT, ms, i + 1, {24'h0, rec_at(5 + i, cur)}, 1'b0);
         end
      endcase
   endtask

   task automatic record_byte(logic [7:0] b);
      int k;
      int need;
      int f;
      k = -1;
      if (rec_fill < BUF_DEPTH) rec_mem[rec_fill] = b;
      rec_fill++;
      f = rec_fill;
      if (f < 4) return;
      for (int i = 3; i >= 0; i--)
         if (type_code[i] == rec_mem[0][3:0]) k = i;
      if (k < 0) begin
         stopped = 1'b1;
         rec_fill = '0;
         return;
      end
      case (k)
         KIND_TEMP: need = 7;
         KIND_RAW:  need = 22;
         KIND_QUAT: need = 36;
         default: need = (f < 5) ? 5 :
                         5 + ((rec_mem[4] > MAX_TEXT_CHARS) ? MAX_TEXT_CHARS : rec_mem[4]);
      endcase
      if (f >= need) begin
         emit_record(k, b);
         rec_fill = '0;
      end
   endtask

   task automatic clear_packet();
      byte_pos = '0;
      pay_len = '0;
      rec_fill = '0;
      stopped = 1'b0;
   endtask

   // advance the model by one accepted byte
   task automatic parse_byte(pkt_byte_type it);
      int n_prior;
      n_prior = value_q.size();
      if (byte_pos == 4) pay_len = {8'h0, it.data};
      else if (byte_pos == 5) pay_len[15:8] = it.data;
      else if (byte_pos >= HDR_BYTES && byte_pos < HDR_BYTES + pay_len && !stopped)
         record_byte(it.data);
      if (byte_pos != POS_MAX) byte_pos++;
      if (it.last) begin
         push_value(KIND_STATUS, '0, 0, '0, byte_pos >= HDR_BYTES);
         clear_packet();
      end
      if (value_q.size() > n_prior) value_q[value_q.size() - 1].last = 1'b1;
   endtask

   // sender: holds the offered beat until taken, otherwise idles at random
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(byte_q[0]);
            void'(byte_q.pop_front());
            n_bytes++;
         end
         if (req_tvalid && !req_tready)
            offer = 1'b1;
         else
            offer = byte_q.size() > 0 && (no_idle || $urandom_range(99) >= 24);
         req_tvalid <= offer;
         if (offer) begin
            req_tdata <= byte_q[0].data;
            req_tlast <= byte_q[0].last;
         end
      end
   end

   // receiver: random backpressure, plus a long hold-off on request
   int  hold_left = 0;
   bit  hold_seen = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || $urandom_range(99) >= 24;
      end
   end

   // value checker
   always @(posedge clock) begin
      value_beat_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_values++;
         if (value_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat %h kind %0d last %b", $time, rsp_tdata,
                     rsp_tuser, rsp_tlast);
         end else begin
            e = value_q.pop_front();
            if (rsp_tuser !== e.kind || rsp_tdata[27:0] !== e.ms ||
                rsp_tdata[33:28] !== e.idx || rsp_tdata[65:34] !== e.val ||
                rsp_tdata[66] !== e.ok || rsp_tdata[71:67] !== 5'b00000 ||
                rsp_tlast !== e.last) begin
               errors++;
               $display("%0t: mismatch exp kind %0d ms %0d idx %0d val %h ok %b last %b",
                        $time, e.kind, e.ms, e.idx, e.val, e.ok, e.last);
               $display("%0t:          got kind %0d ms %0d idx %0d val %h ok %b last %b",
                        $time, rsp_tuser, rsp_tdata[27:0], rsp_tdata[33:28],
                        rsp_tdata[65:34], rsp_tdata[66], rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout: %0d bytes pending, %0d values owed", byte_q.size(), value_q.size());
         $display("[sensor_ensemble_packet_parser_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // one write beat with an idle cycle ahead of it
   task automatic csr_write(logic [1:0] idx, logic [3:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      type_code[idx] = v;
   endtask

   // wait for the parser to drain, then a margin for a quaternion root in flight
   task automatic wait_idle();
      while (byte_q.size() > 0 || value_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add16(logic [15:0] v);
      body = {body, v[7:0], v[15:8]};
   endtask

   task automatic add32(logic [31:0] v);
      add16(v[15:0]);
      add16(v[31:16]);
   endtask

   task automatic add_hdr(logic [3:0] code);
      add32({28'($urandom_range(0, 32'h0FFF_FFFF)), code});
   endtask

   task automatic add_temp(logic [15:0] t, logic [7:0] flag);
      add_hdr(type_code[REG_TEMP_CODE]);
      add16(t);
      body = {body, flag};
   endtask

   task automatic add_imu(bit quat, logic [31:0] q1, logic [31:0] q2, logic [31:0] q3,
                          logic [15:0] acc);
      add_hdr(quat ? type_code[REG_QUAT_CODE] : type_code[REG_RAW_CODE]);
      for (int i = 0; i < 9; i++) add16(16'($urandom));
      if (quat) begin
         add32(q1);
         add32(q2);
         add32(q3);
         add16(acc);
      end
   endtask

   task automatic add_text(logic [7:0] c);
      int n;
      add_hdr(type_code[REG_TEXT_CODE]);
      body = {body, c};
      n = (c > MAX_TEXT_CHARS) ? MAX_TEXT_CHARS : c;
      for (int i = 0; i < n; i++) body = {body, 8'($urandom)};
   endtask

   function automatic logic [3:0] unknown_code();
      logic [3:0] c;
      do c = 4'($urandom_range(15));
      while (c == type_code[0] || c == type_code[1] || c == type_code[2] ||
             c == type_code[3]);
      return c;
   endfunction

   // header, body and trailing bytes; the length field may differ from the body
   task automatic send_packet(int len, int extra);
      pkt_byte_type it;
      logic [7:0] hdr[6];
      for (int i = 0; i < 4; i++) hdr[i] = 8'($urandom);
      hdr[4] = len[7:0];
      hdr[5] = len[15:8];
      for (int i = 0; i < extra; i++) body = {body, 8'($urandom)};
      for (int i = 0; i < 6 + body.size(); i++) begin
         it.data = (i < 6) ? hdr[i] : body[i - 6];
         it.last = (i == 5 + body.size());
         byte_q = {byte_q, it};
      end
      body.delete();
      n_packets++;
   endtask

   task automatic send_short(int n);
      pkt_byte_type it;
      for (int i = 0; i < n; i++) begin
         it.data = 8'($urandom);
         it.last = (i == n - 1);
         byte_q = {byte_q, it};
      end
      n_packets++;
   endtask

   function automatic logic [31:0] rand_q();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
         2: return $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
         default: return $urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000;
      endcase
   endfunction

   task automatic random_packets(int count);
      int len, sel;
      for (int p = 0; p < count; p++) begin
         sel = $urandom_range(99);
         if (sel < 6) begin
            send_short($urandom_range(1, 5));
            continue;
         end
         case ($urandom_range(9))
            0, 1, 2: add_temp(16'($urandom), ($urandom_range(1)) ? 8'h00 : 8'($urandom));
            3, 4:    add_imu(1'b0, '0, '0, '0, '0);
            5, 6:    add_imu(1'b1, rand_q(), rand_q(), rand_q(),
                             $urandom_range(1) ? 16'($urandom_range(600, 800))
                                               : 16'($urandom));
            7, 8:    add_text($urandom_range(9) == 0 ? 8'($urandom_range(255))
                                                     : 8'($urandom_range(0, 8)));
            default: begin
               add32({28'($urandom_range(0, 32'h0FFF_FFFF)), unknown_code()});
               add16(16'($urandom));
            end
         endcase
         len = body.size();
         if (sel >= 94) len = $urandom_range(0, len);
         else if (sel >= 88) len = len + $urandom_range(1, 40);
         else if (sel == 87) len = $urandom_range(0, 16'hFFFF);
         send_packet(len, $urandom_range(0, 3));
      end
   endtask

   initial begin
      type_code[REG_TEMP_CODE] = TEMP_CODE_RST;
      type_code[REG_RAW_CODE]  = RAW_CODE_RST;
      type_code[REG_QUAT_CODE] = QUAT_CODE_RST;
      type_code[REG_TEXT_CODE] = TEXT_CODE_RST;
      clear_packet();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: temperature, text and quaternion records at their extremes, default codes,
      // long receiver hold-off up front so the input stalls
      hold_toggle = ~hold_toggle;
      add_temp(16'h7FFF, 8'h00);
      add_temp(16'h8000, 8'hFF);
      add_text(8'd0);
      send_packet(17, 0);                // text record cut off by the length field
      send_short(1);
      send_short(5);
      send_packet(0, 2);                 // empty payload, trailing bytes ignored
      add_imu(1'b1, '0, '0, '0, 16'd714);
      add_imu(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 16'd715);
      send_packet(72, 0);
      add_text(8'd255);                  // count clamped, 37-byte record
      send_packet(37, 0);
      add_temp(16'h1234, 8'h01);
      add32({28'h0FF_FFFF, unknown_code()});
      add_temp(16'h0001, 8'h01);         // after unknown type: ignored
      send_packet(25, 1);
      add_temp(16'hFFFF, 8'h02);
      send_packet(7, 0);                 // final byte also closes the record
      wait_idle();

      // random phase at reset codes
      random_packets(1);
      wait_idle();

      // temperature and raw codes at the extremes, no idling on either side
      csr_write(REG_TEMP_CODE, 4'd0);
      csr_write(REG_RAW_CODE, 4'd15);
      csr_write(REG_QUAT_CODE, 4'd7);
      csr_write(REG_TEXT_CODE, 4'd8);
      no_idle = 1'b1;
      random_packets(1);
      wait_idle();
      no_idle = 1'b0;

      // shared codes: temperature wins over raw, quaternion over text
      csr_write(REG_TEMP_CODE, 4'd5);
      csr_write(REG_RAW_CODE, 4'd5);
      csr_write(REG_QUAT_CODE, 4'd10);
      csr_write(REG_TEXT_CODE, 4'd10);
      random_packets(1);
      wait_idle();

      csr_write(REG_TEMP_CODE, 4'd3);
      csr_write(REG_RAW_CODE, 4'd9);
      csr_write(REG_QUAT_CODE, 4'd0);
      csr_write(REG_TEXT_CODE, 4'd15);
      hold_toggle = ~hold_toggle;
      random_packets(1);
      wait_idle();

      $display("covered %0d packets, %0d bytes, %0d value beats over 4 code settings",
               n_packets, n_bytes, n_values);
      if (errors == 0)
         $display("[sensor_ensemble_packet_parser_unit] OK");
      else
         $display("[sensor_ensemble_packet_parser_unit] ERROR");
      $finish;
   end

endmodule
